// File: sv/cls_pkg.sv
// shared constants, codes and types for the circular list store
`default_nettype none
package cls_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int STEP_W   = 16;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_JOSEPHUS = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE
  } chain_op_e;

  typedef struct packed {
    chain_op_e                 op;
    logic [IDX_W-1:0]          idx;
    logic signed [WORD_W-1:0]  word;
  } chain_ctrl_t;

endpackage
`default_nettype wire

// File: sv/cls_if.sv
// handshake channels for commands and results
`default_nettype none
interface cls_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cls_pkg::CMD_W-1:0]            cmd;
  logic [cls_pkg::POS_W-1:0]            position;
  logic signed [cls_pkg::WORD_W-1:0]    value;
  logic [cls_pkg::STEP_W-1:0]           step;

  modport source (output valid, cmd, position, value, step, input ready);
  modport sink   (input valid, cmd, position, value, step, output ready);
endinterface

interface cls_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cls_pkg::WORD_W-1:0]    survivor;
  logic [cls_pkg::STAT_W-1:0]           status;
  logic [cls_pkg::COUNT_W-1:0]          count;

  modport source (output valid, survivor, status, count, input ready);
  modport sink   (input valid, survivor, status, count, output ready);
endinterface
`default_nettype wire

// File: sv/cls_cell.sv
// one storage cell of the sequence row
`default_nettype none
module cls_cell (
  input  wire logic                              clk_i,
  input  wire cls_pkg::chain_ctrl_t              ctrl_i,
  input  wire logic [cls_pkg::IDX_W-1:0]         idx_i,
  input  wire logic signed [cls_pkg::WORD_W-1:0] left_i,
  input  wire logic signed [cls_pkg::WORD_W-1:0] right_i,
  output logic signed [cls_pkg::WORD_W-1:0]      data_o
);

  logic signed [cls_pkg::WORD_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      cls_pkg::OP_INSERT: begin
        if (idx_i > ctrl_i.idx) begin
          data_d = left_i;
        end else if (idx_i == ctrl_i.idx) begin
          data_d = ctrl_i.word;
        end
      end
      cls_pkg::OP_DELETE: begin
        if (idx_i >= ctrl_i.idx) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// File: sv/cls_chain.sv
// row of cells holding the sequence, shifting on insert and delete
`default_nettype none
module cls_chain (
  input  wire logic                              clk_i,
  input  wire cls_pkg::chain_ctrl_t              ctrl_i,
  output logic signed [cls_pkg::WORD_W-1:0]      head_o
);

  logic signed [cls_pkg::WORD_W-1:0] data [cls_pkg::CAPACITY];

  for (genvar g = 0; g < cls_pkg::CAPACITY; g++) begin : g_cell
    logic signed [cls_pkg::WORD_W-1:0] left, right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = data[g-1];
    end

    // the last cell keeps its own word when the row closes up
    if (g == cls_pkg::CAPACITY - 1) begin : g_last
      assign right = data[g];
    end else begin : g_mid_r
      assign right = data[g+1];
    end

    cls_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (cls_pkg::IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[g])
    );
  end

  assign head_o = data[0];

endmodule
`default_nettype wire

// File: sv/cls_mod.sv
// restoring remainder unit, one dividend bit per cycle
`default_nettype none
module cls_mod (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [cls_pkg::STEP_W-1:0]   dividend_i,
  input  wire logic [cls_pkg::CNT_W-1:0]    divisor_i,
  output logic                              done_o,
  output logic [cls_pkg::IDX_W-1:0]         rem_o
);

  localparam int CNT_BITS = $clog2(cls_pkg::STEP_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_BITS-1:0]           cnt_q, cnt_d;
  logic [cls_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [cls_pkg::CNT_W-1:0]     dsr_q, dsr_d;
  logic [cls_pkg::STEP_W-1:0]    dvd_q, dvd_d;
  logic [cls_pkg::CNT_W:0]       trial;

  assign trial = {rem_q, dvd_q[cls_pkg::STEP_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(cls_pkg::STEP_W - 1);
      rem_d  = '0;
      dsr_d  = divisor_i;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = cls_pkg::CNT_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[cls_pkg::CNT_W-1:0];
      end
      dvd_d = {dvd_q[cls_pkg::STEP_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  // remainder stays below the divisor, which is at most the capacity
  assign rem_o  = rem_q[cls_pkg::IDX_W-1:0];

endmodule
`default_nettype wire

// File: sv/circular_list_store_josephus_top.sv
// top level of the circular list store with josephus elimination
// usage:
//   in_i carries one command word: cmd, position, value and step.
//   out_o returns exactly one result word per command: survivor,
//   status and the element count after the command.
// timing:
//   insert and delete take the accept cycle; the result is registered
//   and shows on out_o in the next cycle.
//   josephus first reduces step mod length in the remainder unit, then
//   hands over to the cell row, which removes one element per cycle,
//   and last loads the result into the output register.
// stalls:
//   a finished result waits in the output register; a new command is
//   taken once the sequencer is idle and the output register is free or
//   being emptied in that same cycle.
// reset:
//   the length returns to zero and no result is pending; stored words
//   keep whatever they held and are read only below the length.
`default_nettype none
module circular_list_store_josephus_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cls_in_if.sink     in_i,
  cls_out_if.source  out_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_ELIM = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [cls_pkg::CNT_W-1:0]         fill_q, fill_d;
  logic [cls_pkg::IDX_W-1:0]         cur_q, cur_d;

  logic                              out_valid_q, out_valid_d;
  logic signed [cls_pkg::WORD_W-1:0] out_surv_q, out_surv_d;
  logic [cls_pkg::STAT_W-1:0]        out_stat_q, out_stat_d;
  logic [cls_pkg::COUNT_W-1:0]       out_cnt_q, out_cnt_d;

  cls_pkg::chain_ctrl_t              ctrl;
  logic signed [cls_pkg::WORD_W-1:0] head;
  logic                              accept;
  logic                              mod_start, mod_done;
  logic [cls_pkg::IDX_W-1:0]         mod_rem;
  logic [cls_pkg::IDX_W-1:0]         victim;
  logic                              cur_is_last, victim_is_last;

  // take a word only when idle and the result slot is free next cycle
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // next victim is the follower of the current element, wrapping at the end
  assign cur_is_last    = (cls_pkg::CNT_W'(cur_q) + cls_pkg::CNT_W'(1)) == fill_q;
  assign victim         = cur_is_last ? '0 : cur_q + cls_pkg::IDX_W'(1);
  assign victim_is_last = (cls_pkg::CNT_W'(victim) + cls_pkg::CNT_W'(1)) >= fill_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_surv_d  = out_surv_q;
    out_stat_d  = out_stat_q;
    out_cnt_d   = out_cnt_q;
    ctrl.op     = cls_pkg::OP_HOLD;
    ctrl.idx    = cls_pkg::IDX_W'(in_i.position);
    ctrl.word   = in_i.value;
    mod_start   = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_surv_d = '0;
          out_stat_d = cls_pkg::STAT_OK;
          unique case (in_i.cmd)
            cls_pkg::CMD_INSERT: begin
              // range check comes before the full check
              if (cls_pkg::CMP_W'(in_i.position) > cls_pkg::CMP_W'(fill_q)) begin
                out_stat_d = cls_pkg::STAT_RANGE;
              end else if (fill_q >= cls_pkg::CNT_W'(cls_pkg::CAPACITY)) begin
                out_stat_d = cls_pkg::STAT_FULL;
              end else begin
                ctrl.op = cls_pkg::OP_INSERT;
                fill_d  = fill_q + cls_pkg::CNT_W'(1);
              end
            end
            cls_pkg::CMD_DELETE: begin
              if (cls_pkg::CMP_W'(in_i.position) >= cls_pkg::CMP_W'(fill_q)) begin
                out_stat_d = cls_pkg::STAT_RANGE;
              end else begin
                ctrl.op = cls_pkg::OP_DELETE;
                fill_d  = fill_q - cls_pkg::CNT_W'(1);
              end
            end
            cls_pkg::CMD_JOSEPHUS: begin
              if (fill_q == '0) begin
                out_stat_d = cls_pkg::STAT_EMPTY;
              end else begin
                mod_start = 1'b1;
              end
            end
            default: begin
              // unused code leaves the store alone
            end
          endcase
          if (mod_start) begin
            state_d = ST_MOD;
          end else begin
            out_valid_d = 1'b1;
            out_cnt_d   = cls_pkg::COUNT_W'(fill_d);
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          cur_d   = mod_rem;
          state_d = ST_ELIM;
        end
      end
      ST_ELIM: begin
        if (fill_q == cls_pkg::CNT_W'(1)) begin
          // one left: it sits at the head of the row
          out_valid_d = 1'b1;
          out_surv_d  = head;
          out_stat_d  = cls_pkg::STAT_OK;
          out_cnt_d   = cls_pkg::COUNT_W'(fill_q);
          state_d     = ST_IDLE;
        end else begin
          ctrl.op  = cls_pkg::OP_DELETE;
          ctrl.idx = victim;
          fill_d   = fill_q - cls_pkg::CNT_W'(1);
          // the victim's follower slides into its slot, or wraps to the head
          cur_d    = victim_is_last ? '0 : victim;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_surv_q <= out_surv_d;
    out_stat_q <= out_stat_d;
    out_cnt_q  <= out_cnt_d;
  end

  // start position: step mod length
  cls_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_i.step),
    .divisor_i  (fill_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // sequence storage
  cls_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  assign out_o.valid    = out_valid_q;
  assign out_o.survivor = out_surv_q;
  assign out_o.status   = out_stat_q;
  assign out_o.count    = out_cnt_q;

endmodule
`default_nettype wire

// File: bench/tb.sv
// self-checking bench for the circular list store with josephus elimination
`timescale 1ns / 100ps
module tb;

  // unused command code, the block must answer ok and change nothing
  localparam logic [cls_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 120;   // longer than the longest josephus
  localparam int QUIET_TAIL   = 120;   // last words go out with no idling
  localparam int PRINT_CAP    = 30;

  typedef struct packed {
    logic [cls_pkg::CMD_W-1:0]         cmd;
    logic [cls_pkg::POS_W-1:0]         position;
    logic signed [cls_pkg::WORD_W-1:0] value;
    logic [cls_pkg::STEP_W-1:0]        step;
  } list_cmd_t;

  typedef struct packed {
    logic signed [cls_pkg::WORD_W-1:0] survivor;
    logic [cls_pkg::STAT_W-1:0]        status;
    logic [cls_pkg::COUNT_W-1:0]       count;
  } list_result_t;

  logic clk_i;
  logic rst_ni;

  cls_in_if  cmd_if ();
  cls_out_if res_if ();

  circular_list_store_josephus_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // command words waiting to be driven, and results the block still owes us
  list_cmd_t    cmd_backlog [$];
  list_result_t due_results [$];

  // shadow of the sequence as the block should hold it
  logic signed [cls_pkg::WORD_W-1:0] seq_mem [cls_pkg::CAPACITY];
  int unsigned                       seq_len = 0;

  // rough length seen by the generator, so most positions land in range
  int unsigned gen_len = 0;

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned accept_cnt   = 0;
  int unsigned status_tally [4] = '{default: 0};
  int unsigned josephus_cnt = 0;
  int unsigned longest_seq  = 0;
  int unsigned in_gap;
  int unsigned out_gap;
  list_cmd_t   held_cmd;
  list_cmd_t   next_cmd;
  list_result_t want;

  // ---------------------------------------------------------------------------
  // predictor: sequence store with every-second elimination
  // ---------------------------------------------------------------------------

  // close the gap left by element idx
  function automatic void drop_element(int unsigned idx);
    for (int unsigned i = idx; i + 1 < seq_len; i++) seq_mem[i] = seq_mem[i + 1];
    seq_len--;
  endfunction

  function automatic list_result_t apply_list_command(list_cmd_t c);
    list_result_t r;
    int unsigned  cur;
    int unsigned  victim;
    r.survivor = '0;
    r.status   = cls_pkg::STAT_OK;
    case (c.cmd)
      cls_pkg::CMD_INSERT: begin
        // range check comes ahead of the full check
        if (c.position > seq_len) begin
          r.status = cls_pkg::STAT_RANGE;
        end else if (seq_len >= cls_pkg::CAPACITY) begin
          r.status = cls_pkg::STAT_FULL;
        end else begin
          for (int unsigned i = seq_len; i > c.position; i--) seq_mem[i] = seq_mem[i - 1];
          seq_mem[c.position] = c.value;
          seq_len++;
        end
      end
      cls_pkg::CMD_DELETE: begin
        if (c.position >= seq_len) r.status = cls_pkg::STAT_RANGE;
        else drop_element(c.position);
      end
      cls_pkg::CMD_JOSEPHUS: begin
        if (seq_len == 0) begin
          r.status = cls_pkg::STAT_EMPTY;
        end else begin
          cur = c.step % seq_len;
          while (seq_len > 1) begin
            victim = (cur + 1) % seq_len;
            // the victim's follower slides into the victim's slot, or wraps to 0
            cur = (victim + 1 < seq_len) ? victim : 0;
            drop_element(victim);
          end
          r.survivor = seq_mem[0];
        end
      end
      default: ;
    endcase
    r.count = seq_len[cls_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  task automatic queue_cmd(logic [cls_pkg::CMD_W-1:0] c, int unsigned p,
                           logic signed [cls_pkg::WORD_W-1:0] v, int unsigned s);
    list_cmd_t w;
    w.cmd      = c;
    w.position = p[cls_pkg::POS_W-1:0];
    w.value    = v;
    w.step     = s[cls_pkg::STEP_W-1:0];
    cmd_backlog.push_back(w);
    case (c)
      cls_pkg::CMD_INSERT:   if (p <= gen_len && gen_len < cls_pkg::CAPACITY) gen_len++;
      cls_pkg::CMD_DELETE:   if (p < gen_len) gen_len--;
      cls_pkg::CMD_JOSEPHUS: if (gen_len > 1) gen_len = 1;
      default: ;
    endcase
  endtask

  // anything the fields allow: spare code, positions up to 127, random step
  task automatic queue_noise();
    queue_cmd(cls_pkg::CMD_W'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom,
              $urandom_range(0, 65535));
  endtask

  function automatic int unsigned pick_step();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 130);
    return $urandom_range(0, 65535);
  endfunction

  task automatic build_directed();
    queue_cmd(cls_pkg::CMD_JOSEPHUS, 0, 0, 0);           // josephus on an empty store
    queue_cmd(cls_pkg::CMD_DELETE, 0, 0, 0);             // delete on an empty store
    queue_cmd(cls_pkg::CMD_INSERT, 1, 32'sd5, 0);        // insert past the length
    queue_cmd(cls_pkg::CMD_INSERT, 127, 32'sd5, 0);      // largest position
    queue_cmd(CMD_SPARE, 127, -32'sd1, 65535);           // spare code does nothing
    queue_cmd(cls_pkg::CMD_INSERT, 0, 32'h8000_0000, 0); // most negative word
    queue_cmd(cls_pkg::CMD_JOSEPHUS, 0, 0, 65535);       // single element survives
    queue_cmd(cls_pkg::CMD_INSERT, 1, 32'h7fff_ffff, 0); // append, most positive word
    queue_cmd(cls_pkg::CMD_INSERT, 0, -32'sd1, 0);       // insert at the front
    queue_cmd(cls_pkg::CMD_INSERT, 1, 32'h5555_5555, 0); // insert in the middle
    queue_cmd(cls_pkg::CMD_INSERT, 5, 32'sd9, 0);        // one past the end
    queue_cmd(cls_pkg::CMD_INSERT, 4, 32'h2aaa_aaaa, 0); // exactly at the end
    queue_cmd(cls_pkg::CMD_DELETE, 5, 0, 0);             // delete at the length
    queue_cmd(cls_pkg::CMD_DELETE, 127, 0, 0);
    queue_cmd(cls_pkg::CMD_DELETE, 0, 0, 0);             // head delete
    queue_cmd(cls_pkg::CMD_DELETE, 3, 0, 0);             // delete the last element
    queue_cmd(cls_pkg::CMD_JOSEPHUS, 0, 0, 0);           // three elements, step 0
    queue_cmd(cls_pkg::CMD_INSERT, 0, 32'sd7, 0);
    queue_cmd(cls_pkg::CMD_JOSEPHUS, 0, 0, 1);           // two elements, step 1
    queue_cmd(cls_pkg::CMD_INSERT, 1, 32'sd11, 0);
    queue_cmd(cls_pkg::CMD_INSERT, 0, 32'sd13, 0);
    queue_cmd(cls_pkg::CMD_INSERT, 3, 32'sd17, 0);
    queue_cmd(cls_pkg::CMD_JOSEPHUS, 0, 0, 65535);       // step wraps modulo length
    queue_cmd(cls_pkg::CMD_DELETE, 0, 0, 0);             // drain back to empty
  endtask

  // rounds: walk the length to a target with valid commands, sprinkle noise,
  // hammer a full store, then usually eliminate
  task automatic build_random(int unsigned total);
    int unsigned target;
    int unsigned pick;
    while (cmd_backlog.size() < total) begin
      pick = $urandom_range(0, 5);
      if (pick < 2)       target = cls_pkg::CAPACITY;
      else if (pick == 2) target = 0;
      else                target = $urandom_range(1, cls_pkg::CAPACITY - 1);
      while (gen_len != target && cmd_backlog.size() < total) begin
        if ($urandom_range(0, 9) == 0)
          queue_noise();
        else if (gen_len < target)
          queue_cmd(cls_pkg::CMD_INSERT, $urandom_range(0, gen_len), $urandom,
                    $urandom_range(0, 65535));
        else
          queue_cmd(cls_pkg::CMD_DELETE, $urandom_range(0, gen_len - 1), $urandom,
                    $urandom_range(0, 65535));
      end
      if (gen_len == cls_pkg::CAPACITY)
        repeat ($urandom_range(1, 3))
          queue_cmd(cls_pkg::CMD_INSERT, $urandom_range(0, cls_pkg::CAPACITY), $urandom, 0);
      if ($urandom_range(0, 3) != 0)
        queue_cmd(cls_pkg::CMD_JOSEPHUS, $urandom_range(0, 127), $urandom, pick_step());
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset, run control
  // ---------------------------------------------------------------------------

  always #1 clk_i = ~clk_i;

  // idling is off in calm stretches and once the backlog runs low
  function automatic bit idle_allowed();
    return ((cycle_cnt / 512) % 4 != 3) && (cmd_backlog.size() >= QUIET_TAIL);
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatch_cnt < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;

    build_directed();
    build_random(cmd_backlog.size() + RANDOM_ITEMS);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // everything handed over and answered, then let the block settle
    while (cmd_backlog.size() != 0 || cmd_if.valid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d command words, %0d results; josephus %0d, longest sequence %0d",
             accept_cnt, result_cnt, josephus_cnt, longest_seq);
    $display("status ok %0d, range %0d, full %0d, empty %0d; %0d mismatches",
             status_tally[cls_pkg::STAT_OK], status_tally[cls_pkg::STAT_RANGE],
             status_tally[cls_pkg::STAT_FULL], status_tally[cls_pkg::STAT_EMPTY],
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: predicts each accepted word, then offers the next one
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid    <= 1'b0;
      cmd_if.cmd      <= '0;
      cmd_if.position <= '0;
      cmd_if.value    <= '0;
      cmd_if.step     <= '0;
      in_gap = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        held_cmd.cmd      = cmd_if.cmd;
        held_cmd.position = cmd_if.position;
        held_cmd.value    = cmd_if.value;
        held_cmd.step     = cmd_if.step;
        want = apply_list_command(held_cmd);
        due_results.push_back(want);
        status_tally[want.status]++;
        accept_cnt++;
        if (held_cmd.cmd == cls_pkg::CMD_JOSEPHUS) josephus_cnt++;
        if (seq_len > longest_seq) longest_seq = seq_len;
      end
      // a word that is offered stays put until taken
      if (!cmd_if.valid || cmd_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          cmd_if.valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 6);
          cmd_if.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          next_cmd = cmd_backlog.pop_front();
          cmd_if.cmd      <= next_cmd.cmd;
          cmd_if.position <= next_cmd.position;
          cmd_if.value    <= next_cmd.value;
          cmd_if.step     <= next_cmd.step;
          cmd_if.valid    <= 1'b1;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each taken result against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing owed", result_cnt));
        end else begin
          want = due_results.pop_front();
          if (res_if.survivor !== want.survivor)
            note_mismatch($sformatf("result %0d survivor %0d, expected %0d", result_cnt,
                                    res_if.survivor, want.survivor));
          if (res_if.status !== want.status)
            note_mismatch($sformatf("result %0d status %0d, expected %0d", result_cnt,
                                    res_if.status, want.status));
          if (res_if.count !== want.count)
            note_mismatch($sformatf("result %0d count %0d, expected %0d", result_cnt,
                                    res_if.count, want.count));
        end
        result_cnt++;
      end
      // back-pressure in bursts, never in the quiet tail
      if (out_gap > 0) begin
        out_gap--;
        res_if.ready <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 6);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

endmodule
